// ===== rtl/multicast_membership_table_unit_defines.svh =====
// Assertion macros shared by the multicast membership table RTL.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef MULTICAST_MEMBERSHIP_TABLE_UNIT_DEFINES_SVH
`define MULTICAST_MEMBERSHIP_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MMT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MMT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mmt_pkg.sv =====
// Shared sizes, codes, record types and helpers of the membership table.
// Used by the ring modules and the top level.
package mmt_pkg;

    localparam int ENTRIES     = 16;
    localparam int CLIENTS     = 8;
    localparam int QUERY_SLOTS = 8;
    localparam int TIMER_BITS  = 16;

    localparam int EIW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CIW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int SIW = (QUERY_SLOTS > 1) ? $clog2(QUERY_SLOTS) : 1;

    typedef logic [TIMER_BITS-1:0] timer_t;

    localparam logic [32:0] TMAX  = (33'd1 << TIMER_BITS) - 33'd1;
    localparam timer_t      T_ONE = timer_t'(1);

    // Command codes.
    localparam logic [2:0] CMD_IS_EXCL = 3'd0;
    localparam logic [2:0] CMD_TO_EXCL = 3'd1;
    localparam logic [2:0] CMD_TO_INCL = 3'd2;
    localparam logic [2:0] CMD_TICK    = 3'd3;
    localparam logic [2:0] CMD_ACCEPT  = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] REG_MEMB_TICKS = 3'd0;
    localparam logic [2:0] REG_LM_TICKS   = 3'd1;
    localparam logic [2:0] REG_QI_TICKS   = 3'd2;
    localparam logic [2:0] REG_QCOUNT     = 3'd3;
    localparam logic [2:0] REG_ROBUST     = 3'd4;

    typedef enum logic [1:0] {E_SCAN, E_EXCL, E_INCL, E_TICK} entry_op_t;
    typedef enum logic {C_SCAN, C_WRITE} client_op_t;
    typedef enum logic {S_ALLOC, S_TICK} slot_op_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] client;
        logic [31:0] group;
        logic        excl;
        logic        running;
        timer_t      cd;
    } entry_rec_t;

    typedef struct packed {
        logic        known;
        logic [31:0] key;
        logic        sflag;
    } client_rec_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] client;
        logic [31:0] group;
        logic        sflag;
        logic [3:0]  rem;
        timer_t      cd;
    } slot_rec_t;

    typedef struct packed {
        logic      start;
        entry_op_t op;
    } entry_ctrl_t;

    typedef struct packed {
        logic done;
        logic found;
        logic free;
        logic accept;
    } entry_stat_t;

    typedef struct packed {
        logic       start;
        client_op_t op;
        logic       val;
    } client_ctrl_t;

    typedef struct packed {
        logic done;
        logic found;
        logic free;
        logic sflag;
    } client_stat_t;

    typedef struct packed {
        logic     start;
        slot_op_t op;
    } slot_ctrl_t;

    typedef struct packed {
        logic done;
        logic took;
    } slot_stat_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] client;
        logic [31:0] group;
        logic        sflag;
    } slot_emit_t;

    typedef struct packed {
        logic        accept;
        logic        query_valid;
        logic [31:0] query_src;
        logic [31:0] query_group;
        logic        query_sflag;
        logic [2:0]  query_qrv;
        logic        overflow;
        logic        last;
    } res_t;

    // Timer load: saturates to the timer range.
    function automatic timer_t load_time(input logic [15:0] v);
        logic [32:0] w;
        w = {17'd0, v};
        if (w > TMAX) begin
            return TMAX[TIMER_BITS-1:0];
        end
        return w[TIMER_BITS-1:0];
    endfunction

endpackage

// ===== rtl/mmt_ifs.sv =====
// Channel interfaces of the membership table: command, result, configuration.
// Depends on nothing but plain logic types.
interface mmt_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [31:0] client_addr;
    logic [31:0] group_addr;
    logic [31:0] client_mask;

    modport source (output valid, command, client_addr, group_addr, client_mask,
                    input ready);
    modport sink (input valid, command, client_addr, group_addr, client_mask,
                  output ready);
endinterface

interface mmt_res_if;
    logic        valid;
    logic        ready;
    logic        accept;
    logic        query_valid;
    logic [31:0] query_src;
    logic [31:0] query_group;
    logic        query_sflag;
    logic [2:0]  query_qrv;
    logic        overflow;
    logic        last;

    modport source (output valid, accept, query_valid, query_src, query_group,
                    query_sflag, query_qrv, overflow, last, input ready);
    modport sink (input valid, accept, query_valid, query_src, query_group,
                  query_sflag, query_qrv, overflow, last, output ready);
endinterface

interface mmt_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/mmt_entry_ring.sv =====
// Ring of entry cells: during a pass, records rotate one cell per cycle past a head stage.
// Depends on mmt_pkg.
module mmt_entry_ring (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mmt_pkg::entry_ctrl_t ctrl,
    input  logic [31:0]          client,
    input  logic [31:0]          group,
    input  logic [31:0]          mask,
    input  mmt_pkg::timer_t      load,
    output mmt_pkg::entry_stat_t stat
);

    mmt_pkg::entry_rec_t       rec_reg [mmt_pkg::ENTRIES];
    mmt_pkg::entry_rec_t       head;
    mmt_pkg::entry_rec_t       head_next;
    mmt_pkg::entry_op_t        op_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [mmt_pkg::EIW-1:0]   cnt_reg;
    logic                      found_reg;
    logic [mmt_pkg::EIW-1:0]   fidx_reg;
    logic                      free_reg;
    logic [mmt_pkg::EIW-1:0]   free_idx_reg;
    logic                      acc_reg;
    logic                      hit;
    logic                      ahit;
    logic                      last_step;
    logic [mmt_pkg::EIW-1:0]   tgt;

    assign head      = rec_reg[0];
    assign hit       = head.valid && head.client == client && head.group == group;
    assign ahit      = head.valid && head.excl && head.group == group &&
                       ((head.client ^ client) & mask) == 32'd0;
    assign last_step = cnt_reg == mmt_pkg::EIW'(mmt_pkg::ENTRIES - 1);
    assign tgt       = found_reg ? fidx_reg : free_idx_reg;

    // Head stage: the one place where a record is changed.
    always_comb
    begin
        head_next = head;
        unique case (op_reg)
            mmt_pkg::E_SCAN:
            begin
                head_next = head;
            end
            mmt_pkg::E_EXCL:
            begin
                if (cnt_reg == tgt && (found_reg || free_reg))
                begin
                    if (!found_reg)
                    begin
                        head_next.valid  = 1'b1;
                        head_next.client = client;
                        head_next.group  = group;
                    end
                    head_next.excl    = 1'b1;
                    head_next.running = 1'b1;
                    head_next.cd      = load;
                end
            end
            mmt_pkg::E_INCL:
            begin
                if (found_reg && cnt_reg == fidx_reg)
                begin
                    head_next.running = 1'b1;
                    head_next.cd      = load;
                end
            end
            mmt_pkg::E_TICK:
            begin
                if (head.valid && head.running)
                begin
                    if (head.cd <= mmt_pkg::T_ONE)
                    begin
                        head_next.cd      = '0;
                        head_next.running = 1'b0;
                        head_next.excl    = 1'b0;
                    end
                    else
                    begin
                        head_next.cd = head.cd - mmt_pkg::T_ONE;
                    end
                end
            end
            default:
            begin
                head_next = head;
            end
        endcase
    end

    // Rotation, pass control and scan results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
            cnt_reg      <= '0;
            op_reg       <= mmt_pkg::E_SCAN;
            found_reg    <= 1'b0;
            fidx_reg     <= '0;
            free_reg     <= 1'b0;
            free_idx_reg <= '0;
            acc_reg      <= 1'b0;
            for (int i = 0; i < mmt_pkg::ENTRIES; i++)
            begin
                rec_reg[i].valid   <= 1'b0;
                rec_reg[i].running <= 1'b0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                op_reg   <= ctrl.op;
                if (ctrl.op == mmt_pkg::E_SCAN)
                begin
                    found_reg <= 1'b0;
                    free_reg  <= 1'b0;
                    acc_reg   <= 1'b0;
                end
            end
            else if (busy_reg)
            begin
                for (int i = 0; i < mmt_pkg::ENTRIES - 1; i++)
                begin
                    rec_reg[i] <= rec_reg[i+1];
                end
                rec_reg[mmt_pkg::ENTRIES-1] <= head_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (op_reg == mmt_pkg::E_SCAN)
                begin
                    if (hit && !found_reg)
                    begin
                        found_reg <= 1'b1;
                        fidx_reg  <= cnt_reg;
                    end
                    if (!head.valid && !free_reg)
                    begin
                        free_reg     <= 1'b1;
                        free_idx_reg <= cnt_reg;
                    end
                    if (ahit)
                    begin
                        acc_reg <= 1'b1;
                    end
                end
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.done   = done_reg;
    assign stat.found  = found_reg;
    assign stat.free   = free_reg;
    assign stat.accept = acc_reg;

endmodule

// ===== rtl/mmt_client_ring.sv =====
// Ring of client cells holding each known client's S flag.
// Depends on mmt_pkg.
module mmt_client_ring (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mmt_pkg::client_ctrl_t ctrl,
    input  logic [31:0]           client,
    output mmt_pkg::client_stat_t stat
);

    mmt_pkg::client_rec_t      rec_reg [mmt_pkg::CLIENTS];
    mmt_pkg::client_rec_t      head;
    mmt_pkg::client_rec_t      head_next;
    mmt_pkg::client_op_t       op_reg;
    logic                      val_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [mmt_pkg::CIW-1:0]   cnt_reg;
    logic                      found_reg;
    logic [mmt_pkg::CIW-1:0]   fidx_reg;
    logic                      sf_reg;
    logic                      free_reg;
    logic [mmt_pkg::CIW-1:0]   free_idx_reg;
    logic                      hit;
    logic                      last_step;
    logic [mmt_pkg::CIW-1:0]   tgt;

    assign head      = rec_reg[0];
    assign hit       = head.known && head.key == client;
    assign last_step = cnt_reg == mmt_pkg::CIW'(mmt_pkg::CLIENTS - 1);
    assign tgt       = found_reg ? fidx_reg : free_idx_reg;

    // Head stage: writes the S flag of the chosen client.
    always_comb
    begin
        head_next = head;
        if (op_reg == mmt_pkg::C_WRITE && cnt_reg == tgt && (found_reg || free_reg))
        begin
            head_next.known = 1'b1;
            head_next.key   = client;
            head_next.sflag = val_reg;
        end
    end

    // Rotation, pass control and scan results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
            cnt_reg      <= '0;
            op_reg       <= mmt_pkg::C_SCAN;
            val_reg      <= 1'b0;
            found_reg    <= 1'b0;
            fidx_reg     <= '0;
            sf_reg       <= 1'b0;
            free_reg     <= 1'b0;
            free_idx_reg <= '0;
            for (int i = 0; i < mmt_pkg::CLIENTS; i++)
            begin
                rec_reg[i].known <= 1'b0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                op_reg   <= ctrl.op;
                val_reg  <= ctrl.val;
                if (ctrl.op == mmt_pkg::C_SCAN)
                begin
                    found_reg <= 1'b0;
                    free_reg  <= 1'b0;
                    sf_reg    <= 1'b0;
                end
            end
            else if (busy_reg)
            begin
                for (int i = 0; i < mmt_pkg::CLIENTS - 1; i++)
                begin
                    rec_reg[i] <= rec_reg[i+1];
                end
                rec_reg[mmt_pkg::CLIENTS-1] <= head_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (op_reg == mmt_pkg::C_SCAN)
                begin
                    if (hit && !found_reg)
                    begin
                        found_reg <= 1'b1;
                        fidx_reg  <= cnt_reg;
                        sf_reg    <= head.sflag;
                    end
                    if (!head.known && !free_reg)
                    begin
                        free_reg     <= 1'b1;
                        free_idx_reg <= cnt_reg;
                    end
                end
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.done  = done_reg;
    assign stat.found = found_reg;
    assign stat.free  = free_reg;
    assign stat.sflag = sf_reg;

endmodule

// ===== rtl/mmt_slot_ring.sv =====
// Ring of query slot cells that repeat group-specific queries on ticks.
// Depends on mmt_pkg.
module mmt_slot_ring (
    input  logic                clk,
    input  logic                rst_n,
    input  mmt_pkg::slot_ctrl_t ctrl,
    input  logic [31:0]         client,
    input  logic [31:0]         group,
    input  logic                sflag,
    input  logic [3:0]          rem,
    input  mmt_pkg::timer_t     load,
    input  logic                hold,
    output mmt_pkg::slot_emit_t emit,
    output mmt_pkg::slot_stat_t stat
);

    mmt_pkg::slot_rec_t        rec_reg [mmt_pkg::QUERY_SLOTS];
    mmt_pkg::slot_rec_t        head;
    mmt_pkg::slot_rec_t        head_next;
    mmt_pkg::slot_op_t         op_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [mmt_pkg::SIW-1:0]   cnt_reg;
    logic                      took_reg;
    logic                      due;
    logic                      last_step;
    logic                      step;

    assign head      = rec_reg[0];
    assign due       = head.valid && head.cd <= mmt_pkg::T_ONE;
    assign last_step = cnt_reg == mmt_pkg::SIW'(mmt_pkg::QUERY_SLOTS - 1);
    assign step      = busy_reg && !hold;

    // A due slot at the head offers its query while the tick pass runs.
    assign emit.valid  = busy_reg && op_reg == mmt_pkg::S_TICK && due;
    assign emit.client = head.client;
    assign emit.group  = head.group;
    assign emit.sflag  = head.sflag;

    // Head stage: claims the first free slot or advances slot timers.
    always_comb
    begin
        head_next = head;
        unique case (op_reg)
            mmt_pkg::S_ALLOC:
            begin
                if (!took_reg && !head.valid)
                begin
                    head_next.valid  = 1'b1;
                    head_next.client = client;
                    head_next.group  = group;
                    head_next.sflag  = sflag;
                    head_next.rem    = rem;
                    head_next.cd     = load;
                end
            end
            mmt_pkg::S_TICK:
            begin
                if (due)
                begin
                    if (head.rem <= 4'd1)
                    begin
                        head_next.valid = 1'b0;
                        head_next.rem   = 4'd0;
                        head_next.cd    = '0;
                    end
                    else
                    begin
                        head_next.rem = head.rem - 4'd1;
                        head_next.cd  = load;
                    end
                end
                else if (head.valid)
                begin
                    head_next.cd = head.cd - mmt_pkg::T_ONE;
                end
            end
            default:
            begin
                head_next = head;
            end
        endcase
    end

    // Rotation and pass control; the pass stalls while a query cannot leave.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= mmt_pkg::S_ALLOC;
            took_reg <= 1'b0;
            for (int i = 0; i < mmt_pkg::QUERY_SLOTS; i++)
            begin
                rec_reg[i].valid <= 1'b0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                op_reg   <= ctrl.op;
                took_reg <= 1'b0;
            end
            else if (step)
            begin
                for (int i = 0; i < mmt_pkg::QUERY_SLOTS - 1; i++)
                begin
                    rec_reg[i] <= rec_reg[i+1];
                end
                rec_reg[mmt_pkg::QUERY_SLOTS-1] <= head_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (op_reg == mmt_pkg::S_ALLOC && !head.valid)
                begin
                    took_reg <= 1'b1;
                end
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.done = done_reg;
    assign stat.took = took_reg;

endmodule

// ===== rtl/multicast_membership_table_unit.sv =====
// Top level of the multicast membership table: sequencer, configuration and output stage.
// Depends on mmt_pkg, mmt_ifs, the three ring modules and the assertion macro header.
//
//  Channel  Dir  Handshake     Carries
//  req      in   valid/ready   command, client_addr, group_addr, client_mask
//  res      out  valid/ready   accept, query fields, overflow, last
//  cfg      in   valid/ready   index, data (always ready)
//
// One item at a time. Each table pass rotates a ring once through all its cells:
// the entries, the clients or the query slots. A tick makes an entry pass and then
// a slot pass; a to-include with a match makes up to two entry passes, two client
// passes and one slot pass.
// Reset clears valid, running and known bits only; no clearing pass is needed.
// A stalled result holds the slot pass; a new item waits until the last result is queued.
`include "multicast_membership_table_unit_defines.svh"

module multicast_membership_table_unit (
    input logic       clk,
    input logic       rst_n,
    mmt_cmd_if.sink   req,
    mmt_res_if.source res,
    mmt_cfg_if.sink   cfg
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_ESCAN, ST_EWRITE, ST_CSCAN, ST_CWRITE,
        ST_SALLOC, ST_ETICK, ST_STICK, ST_EMIT
    } state_t;

    state_t                state_reg;
    logic [2:0]            cmd_reg;
    logic [31:0]           cli_reg;
    logic [31:0]           grp_reg;
    logic [31:0]           msk_reg;
    logic                  ovf_reg;
    logic                  sf_reg;
    logic [15:0]           memb_reg;
    logic [15:0]           lm_reg;
    logic [15:0]           qi_reg;
    logic [3:0]            qc_reg;
    logic [2:0]            rob_reg;
    mmt_pkg::entry_ctrl_t  e_ctrl_reg;
    mmt_pkg::client_ctrl_t c_ctrl_reg;
    mmt_pkg::slot_ctrl_t   s_ctrl_reg;
    mmt_pkg::entry_stat_t  e_stat;
    mmt_pkg::client_stat_t c_stat;
    mmt_pkg::slot_stat_t   s_stat;
    mmt_pkg::slot_emit_t   s_emit;
    mmt_pkg::res_t         fin_reg;
    mmt_pkg::res_t         out_reg;
    logic                  out_valid_reg;
    mmt_pkg::res_t         pend_reg;
    logic                  pend_valid_reg;
    logic                  can_push;
    logic                  s_hold;
    logic [3:0]            q_rem;
    mmt_pkg::timer_t       e_load;
    mmt_pkg::res_t         empty_res;
    mmt_pkg::res_t         emit_res;
    logic                  req_fire;

    assign req_fire  = req.valid && req.ready;
    assign req.ready = state_reg == ST_IDLE;
    assign cfg.ready = 1'b1;
    assign can_push  = !out_valid_reg || res.ready;
    assign s_hold    = s_emit.valid && pend_valid_reg && !can_push;
    assign q_rem     = (qc_reg > 4'd0) ? qc_reg - 4'd1 : 4'd0;
    assign e_load    = (cmd_reg == mmt_pkg::CMD_TO_INCL) ? mmt_pkg::load_time(lm_reg)
                                                         : mmt_pkg::load_time(memb_reg);

    // Result templates.
    always_comb
    begin
        empty_res      = '0;
        emit_res       = '0;
        emit_res.query_valid = 1'b1;
        emit_res.query_src   = s_emit.client;
        emit_res.query_group = s_emit.group;
        emit_res.query_sflag = s_emit.sflag;
        emit_res.query_qrv   = rob_reg;
    end

    mmt_entry_ring u_entry (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (e_ctrl_reg),
        .client (cli_reg),
        .group  (grp_reg),
        .mask   (msk_reg),
        .load   (e_load),
        .stat   (e_stat)
    );

    mmt_client_ring u_client (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (c_ctrl_reg),
        .client (cli_reg),
        .stat   (c_stat)
    );

    mmt_slot_ring u_slot (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (s_ctrl_reg),
        .client (cli_reg),
        .group  (grp_reg),
        .sflag  (sf_reg),
        .rem    (q_rem),
        .load   (mmt_pkg::load_time(qi_reg)),
        .hold   (s_hold),
        .emit   (s_emit),
        .stat   (s_stat)
    );

    // Sequencer, configuration registers and output stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            memb_reg       <= 16'd260;
            lm_reg         <= 16'd2;
            qi_reg         <= 16'd1;
            qc_reg         <= 4'd2;
            rob_reg        <= 3'd2;
            e_ctrl_reg     <= '0;
            c_ctrl_reg     <= '0;
            s_ctrl_reg     <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            ovf_reg        <= 1'b0;
            sf_reg         <= 1'b0;
        end
        else
        begin
            e_ctrl_reg.start <= 1'b0;
            c_ctrl_reg.start <= 1'b0;
            s_ctrl_reg.start <= 1'b0;

            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    mmt_pkg::REG_MEMB_TICKS: memb_reg <= cfg.data;
                    mmt_pkg::REG_LM_TICKS:   lm_reg   <= cfg.data;
                    mmt_pkg::REG_QI_TICKS:   qi_reg   <= cfg.data;
                    mmt_pkg::REG_QCOUNT:     qc_reg   <= cfg.data[3:0];
                    mmt_pkg::REG_ROBUST:     rob_reg  <= cfg.data[2:0];
                    default: ;
                endcase
            end

            if (out_valid_reg && res.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_fire)
                    begin
                        cmd_reg <= req.command;
                        cli_reg <= req.client_addr;
                        grp_reg <= req.group_addr;
                        msk_reg <= req.client_mask;
                        ovf_reg <= 1'b0;
                        sf_reg  <= 1'b0;
                        if (req.command == mmt_pkg::CMD_TICK)
                        begin
                            e_ctrl_reg <= '{start: 1'b1, op: mmt_pkg::E_TICK};
                            state_reg  <= ST_ETICK;
                        end
                        else if (req.command == mmt_pkg::CMD_IS_EXCL ||
                                 req.command == mmt_pkg::CMD_TO_EXCL ||
                                 req.command == mmt_pkg::CMD_TO_INCL ||
                                 req.command == mmt_pkg::CMD_ACCEPT)
                        begin
                            e_ctrl_reg <= '{start: 1'b1, op: mmt_pkg::E_SCAN};
                            state_reg  <= ST_ESCAN;
                        end
                        else
                        begin
                            fin_reg      <= empty_res;
                            fin_reg.last <= 1'b1;
                            state_reg    <= ST_EMIT;
                        end
                    end
                end
                ST_ESCAN:
                begin
                    if (e_stat.done)
                    begin
                        unique case (cmd_reg)
                            mmt_pkg::CMD_IS_EXCL, mmt_pkg::CMD_TO_EXCL:
                            begin
                                ovf_reg    <= !(e_stat.found || e_stat.free);
                                e_ctrl_reg <= '{start: 1'b1, op: mmt_pkg::E_EXCL};
                                state_reg  <= ST_EWRITE;
                            end
                            mmt_pkg::CMD_TO_INCL:
                            begin
                                if (e_stat.found)
                                begin
                                    c_ctrl_reg <= '{start: 1'b1, op: mmt_pkg::C_SCAN,
                                                    val: 1'b0};
                                    state_reg  <= ST_CSCAN;
                                end
                                else
                                begin
                                    fin_reg      <= empty_res;
                                    fin_reg.last <= 1'b1;
                                    state_reg    <= ST_EMIT;
                                end
                            end
                            default:
                            begin
                                fin_reg        <= empty_res;
                                fin_reg.accept <= e_stat.accept;
                                fin_reg.last   <= 1'b1;
                                state_reg      <= ST_EMIT;
                            end
                        endcase
                    end
                end
                ST_EWRITE:
                begin
                    if (e_stat.done)
                    begin
                        unique case (cmd_reg)
                            mmt_pkg::CMD_TO_EXCL:
                            begin
                                c_ctrl_reg <= '{start: 1'b1, op: mmt_pkg::C_SCAN,
                                                val: 1'b0};
                                state_reg  <= ST_CSCAN;
                            end
                            mmt_pkg::CMD_TO_INCL:
                            begin
                                if (q_rem != 4'd0)
                                begin
                                    s_ctrl_reg <= '{start: 1'b1, op: mmt_pkg::S_ALLOC};
                                    state_reg  <= ST_SALLOC;
                                end
                                else
                                begin
                                    c_ctrl_reg <= '{start: 1'b1, op: mmt_pkg::C_WRITE,
                                                    val: 1'b1};
                                    state_reg  <= ST_CWRITE;
                                end
                            end
                            default:
                            begin
                                fin_reg          <= empty_res;
                                fin_reg.overflow <= ovf_reg;
                                fin_reg.last     <= 1'b1;
                                state_reg        <= ST_EMIT;
                            end
                        endcase
                    end
                end
                ST_CSCAN:
                begin
                    if (c_stat.done)
                    begin
                        if (cmd_reg == mmt_pkg::CMD_TO_INCL)
                        begin
                            sf_reg     <= c_stat.found && c_stat.sflag;
                            e_ctrl_reg <= '{start: 1'b1, op: mmt_pkg::E_INCL};
                            state_reg  <= ST_EWRITE;
                        end
                        else
                        begin
                            c_ctrl_reg <= '{start: 1'b1, op: mmt_pkg::C_WRITE, val: 1'b0};
                            state_reg  <= ST_CWRITE;
                        end
                    end
                end
                ST_SALLOC:
                begin
                    if (s_stat.done)
                    begin
                        if (!s_stat.took)
                        begin
                            ovf_reg <= 1'b1;
                        end
                        c_ctrl_reg <= '{start: 1'b1, op: mmt_pkg::C_WRITE, val: 1'b1};
                        state_reg  <= ST_CWRITE;
                    end
                end
                ST_CWRITE:
                begin
                    if (c_stat.done)
                    begin
                        fin_reg          <= empty_res;
                        fin_reg.overflow <= ovf_reg || !(c_stat.found || c_stat.free);
                        fin_reg.last     <= 1'b1;
                        if (cmd_reg == mmt_pkg::CMD_TO_INCL)
                        begin
                            fin_reg.query_valid <= 1'b1;
                            fin_reg.query_src   <= cli_reg;
                            fin_reg.query_group <= grp_reg;
                            fin_reg.query_sflag <= sf_reg;
                            fin_reg.query_qrv   <= rob_reg;
                        end
                        state_reg <= ST_EMIT;
                    end
                end
                ST_ETICK:
                begin
                    if (e_stat.done)
                    begin
                        s_ctrl_reg <= '{start: 1'b1, op: mmt_pkg::S_TICK};
                        state_reg  <= ST_STICK;
                    end
                end
                ST_STICK:
                begin
                    // Each due query waits in pend_reg so the final one can carry last.
                    if (s_emit.valid && !s_hold)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_reg       <= pend_reg;
                            out_valid_reg <= 1'b1;
                        end
                        pend_reg       <= emit_res;
                        pend_valid_reg <= 1'b1;
                    end
                    if (s_stat.done)
                    begin
                        fin_reg        <= pend_valid_reg ? pend_reg : empty_res;
                        fin_reg.last   <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (can_push)
                    begin
                        out_reg       <= fin_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.accept      = out_reg.accept;
    assign res.query_valid = out_reg.query_valid;
    assign res.query_src   = out_reg.query_src;
    assign res.query_group = out_reg.query_group;
    assign res.query_sflag = out_reg.query_sflag;
    assign res.query_qrv   = out_reg.query_qrv;
    assign res.overflow    = out_reg.overflow;
    assign res.last        = out_reg.last;

    `MMT_ASSERT_NOW(a_entry_done_phase, e_stat.done,
        state_reg == ST_ESCAN || state_reg == ST_EWRITE || state_reg == ST_ETICK,
        "entry pass finished outside an entry phase")
    `MMT_ASSERT_NOW(a_hold_in_tick, s_hold, state_reg == ST_STICK,
        "slot ring held outside the tick pass")
    `MMT_ASSERT_NOW(a_pend_in_tick, pend_valid_reg, state_reg == ST_STICK,
        "held-back query outside the tick pass")
    `MMT_ASSERT_NEXT(a_accept_leaves_idle, req_fire, state_reg != ST_IDLE,
        "accepted item did not start work")

endmodule
